@@ src/sfb_pkg.sv @@
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants and the CRC byte update for the serial frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

  // Command codes carried on the input tuser bit
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY = 1'b1;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned IDX_W  = 4;

  // Frame constants
  localparam logic [LEN_W-1:0]  OVERHEAD_BYTES = 17'd11;
  localparam logic [LEN_W-1:0]  CAP_RESET      = 17'd65546;
  localparam logic [HALF_W-1:0] CRC_INIT       = 16'hFFFF;
  localparam logic [HALF_W-1:0] CRC_POLY       = 16'h1021;

  // Beat positions within a start item
  localparam logic [IDX_W-1:0] BEAT_MARKER    = 4'd0;
  localparam logic [IDX_W-1:0] BEAT_GROUP     = 4'd1;
  localparam logic [IDX_W-1:0] BEAT_CODE      = 4'd2;
  localparam logic [IDX_W-1:0] BEAT_ID_LO     = 4'd3;
  localparam logic [IDX_W-1:0] BEAT_ID_HI     = 4'd4;
  localparam logic [IDX_W-1:0] BEAT_RSVD_LO   = 4'd5;
  localparam logic [IDX_W-1:0] BEAT_RSVD_HI   = 4'd6;
  localparam logic [IDX_W-1:0] BEAT_LEN_LO    = 4'd7;
  localparam logic [IDX_W-1:0] BEAT_LEN_HI    = 4'd8;
  localparam logic [IDX_W-1:0] BEAT_HDR_CRCLO = 4'd9;
  localparam logic [IDX_W-1:0] BEAT_HDR_CRCHI = 4'd10;

  // Beat positions within a payload item
  localparam logic [IDX_W-1:0] BEAT_DATA      = 4'd0;
  localparam logic [IDX_W-1:0] BEAT_PAY_CRCLO = 4'd1;
  localparam logic [IDX_W-1:0] BEAT_PAY_CRCHI = 4'd2;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [HALF_W-1:0] crc_update(input logic [HALF_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [HALF_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[HALF_W-1]) begin
        c = {c[HALF_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[HALF_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/serial_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16
// Expands start and payload beats into framed serial bytes with a CRC-16 trailer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake             Content
// s_axis    in   tvalid / tready       tuser = cmd, tdata = header fields / data byte
// m_axis    out  tvalid / tready       tdata = byte + frame length, tlast, tuser = error
// cfg       in   cfg_valid / cfg_ready index 0 = start marker, 1 = frame capacity
//
// Bytes: a payload beat gives one byte (three when it closes the frame and the two
// CRC bytes follow), a start beat gives nine bytes (eleven for an empty payload,
// one when the frame is rejected). The single output register sends one
// frame byte per cycle while m_axis_tready is high. A payload beat with no
// open frame is dropped and gives no byte.
// Reset: no frame open, CRC at all ones, marker 0, capacity 65546.
// Stalls: the output register holds while m_axis_tready is low and the work
// register then holds the item being expanded; the next input beat is taken
// in the same cycle as the last output byte of the current one.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] group byte, [15:8] op_code, [31:16] message_id,
  // [47:32] payload_length, [55:48] data_byte
  input  logic [55:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [24:8] frame_length, [31:25] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] error
  output logic        m_axis_tuser,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  marker_q;
  logic [16:0] cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
      cap_q    <= sfb_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sfb_pkg::REG_START_MARKER:   marker_q <= cfg_data_i[7:0];
        sfb_pkg::REG_FRAME_CAPACITY: cap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Work register: holds the accepted item while its bytes go out
  // --------------------------------------------------------------------------
  logic        busy_q;
  logic        cmd_q;
  logic [7:0]  grp_q;
  logic [7:0]  code_q;
  logic [15:0] id_q;
  logic [15:0] plen_q;
  logic [7:0]  data_q;
  logic [3:0]  idx_q;

  // Frame state
  logic        open_q;
  logic [15:0] crc_q;
  logic [15:0] left_q;
  logic [16:0] total_q;

  // Output register
  logic        m_valid_q;
  logic [7:0]  m_byte_q;
  logic        m_last_q;
  logic        m_err_q;
  logic [16:0] m_flen_q;

  logic        out_free;
  logic        is_start;
  logic        drop;
  logic        emit;
  logic        item_done;
  logic        in_fire;
  logic [16:0] total_w;
  logic        too_long;

  logic [7:0]  beat_byte;
  logic        beat_last;
  logic        beat_err;
  logic [16:0] beat_flen;
  logic        beat_hash;
  logic        beat_final;
  logic [15:0] crc_next;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign is_start  = (cmd_q == sfb_pkg::CMD_START);
  // drop a payload beat that arrives with no frame open: it produces no bytes
  assign drop      = busy_q && !is_start && !open_q;
  assign emit      = busy_q && !drop && out_free;
  assign item_done = drop || (emit && beat_final);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // take a new item when idle or when the current one finishes this cycle
  assign s_axis_tready = !busy_q || item_done;

  assign total_w  = sfb_pkg::OVERHEAD_BYTES + {1'b0, plen_q};
  assign too_long = (total_w > cap_q);

  // --------------------------------------------------------------------------
  // Byte selection for the current beat
  // --------------------------------------------------------------------------
  always_comb begin
    beat_byte  = '0;
    beat_last  = 1'b0;
    beat_err   = 1'b0;
    beat_flen  = '0;
    beat_hash  = 1'b0;
    beat_final = 1'b0;
    if (is_start) begin
      if (too_long) begin
        // rejected frame: a single error byte
        beat_last  = 1'b1;
        beat_err   = 1'b1;
        beat_final = 1'b1;
      end else begin
        case (idx_q)
          sfb_pkg::BEAT_MARKER: beat_byte = marker_q;
          sfb_pkg::BEAT_GROUP: begin
            beat_byte = grp_q;
            beat_hash = 1'b1;
          end
          sfb_pkg::BEAT_CODE: begin
            beat_byte = code_q;
            beat_hash = 1'b1;
          end
          sfb_pkg::BEAT_ID_LO: begin
            beat_byte = id_q[7:0];
            beat_hash = 1'b1;
          end
          sfb_pkg::BEAT_ID_HI: begin
            beat_byte = id_q[15:8];
            beat_hash = 1'b1;
          end
          sfb_pkg::BEAT_RSVD_LO: beat_hash = 1'b1;
          sfb_pkg::BEAT_RSVD_HI: beat_hash = 1'b1;
          sfb_pkg::BEAT_LEN_LO: begin
            beat_byte = plen_q[7:0];
            beat_hash = 1'b1;
          end
          sfb_pkg::BEAT_LEN_HI: begin
            beat_byte  = plen_q[15:8];
            beat_hash  = 1'b1;
            // an empty payload goes straight on to the trailer
            beat_final = (plen_q != '0);
          end
          sfb_pkg::BEAT_HDR_CRCLO: beat_byte = crc_q[7:0];
          sfb_pkg::BEAT_HDR_CRCHI: begin
            beat_byte  = crc_q[15:8];
            beat_last  = 1'b1;
            beat_flen  = total_q;
            beat_final = 1'b1;
          end
          default: beat_final = 1'b1;
        endcase
      end
    end else begin
      case (idx_q)
        sfb_pkg::BEAT_DATA: begin
          beat_byte  = data_q;
          beat_hash  = 1'b1;
          // the last payload byte of the frame pulls in the trailer
          beat_final = (left_q != 16'd1);
        end
        sfb_pkg::BEAT_PAY_CRCLO: beat_byte = crc_q[7:0];
        sfb_pkg::BEAT_PAY_CRCHI: begin
          beat_byte  = crc_q[15:8];
          beat_last  = 1'b1;
          beat_flen  = total_q;
          beat_final = 1'b1;
        end
        default: beat_final = 1'b1;
      endcase
    end
  end

  assign crc_next = sfb_pkg::crc_update(crc_q, beat_byte);

  // --------------------------------------------------------------------------
  // Work register and beat counter
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (item_done) begin
        busy_q <= 1'b0;
      end
      if (item_done) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= 4'(idx_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= s_axis_tuser;
      grp_q  <= s_axis_tdata[7:0];
      code_q <= s_axis_tdata[15:8];
      id_q   <= s_axis_tdata[31:16];
      plen_q <= s_axis_tdata[47:32];
      data_q <= s_axis_tdata[55:48];
    end
  end

  // --------------------------------------------------------------------------
  // Frame state: advance on every byte that leaves
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      crc_q   <= sfb_pkg::CRC_INIT;
      left_q  <= '0;
      total_q <= '0;
    end else if (emit) begin
      if (is_start) begin
        if (too_long) begin
          open_q  <= 1'b0;
          left_q  <= '0;
          crc_q   <= sfb_pkg::CRC_INIT;
          total_q <= '0;
        end else if (idx_q == sfb_pkg::BEAT_MARKER) begin
          // a new start abandons any open frame
          open_q  <= 1'b0;
          left_q  <= '0;
          crc_q   <= sfb_pkg::CRC_INIT;
          total_q <= total_w;
        end else begin
          if (beat_hash) begin
            crc_q <= crc_next;
          end
          if (idx_q == sfb_pkg::BEAT_LEN_HI && plen_q != '0) begin
            open_q <= 1'b1;
            left_q <= plen_q;
          end
          if (idx_q == sfb_pkg::BEAT_HDR_CRCHI) begin
            open_q <= 1'b0;
            left_q <= '0;
          end
        end
      end else begin
        if (idx_q == sfb_pkg::BEAT_DATA) begin
          crc_q  <= crc_next;
          left_q <= 16'(left_q - 16'd1);
        end
        if (idx_q == sfb_pkg::BEAT_PAY_CRCHI) begin
          open_q <= 1'b0;
          left_q <= '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_byte_q <= beat_byte;
      m_last_q <= beat_last;
      m_err_q  <= beat_err;
      m_flen_q <= beat_flen;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_flen_q, m_byte_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_err_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an open frame has payload bytes still to come, except while its trailer
  // bytes leave
  a_open_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && (is_start || idx_q == sfb_pkg::BEAT_DATA)) |-> (left_q != '0))
    else $error("open frame with no bytes left");

  // a dropped payload beat never produces a byte
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop |=> !(m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)
               && $past(!emit)))
    else $error("dropped payload produced output");

  // an error byte is a zero byte that closes the run with no length
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 32'd0))
    else $error("malformed error beat");

  // frame length appears only on the closing CRC byte
  a_flen_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[24:8] == 17'd0))
    else $error("frame length on a non-final beat");

endmodule
